// ===== sv/bald_pkg.sv =====
// Shared types, field widths and width helpers for the binned audio level meter.
package bald_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int BLOCK_W     = 13;
   localparam int NUM_BINS_W  = 7;
   localparam int INDEX_W     = 6;
   localparam int LEVEL_W     = 16;

   localparam logic [NUM_BINS_W-1:0] NUM_BINS_RESET = 7'd16;
   localparam logic [LEVEL_W-1:0]    LEVEL_FULL     = 16'h8000;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic [BLOCK_W-1:0]         block_samples;
   } bald_req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] bin_index;
      logic [LEVEL_W-1:0] level;
   } bald_rsp_type;

   // bin index into the level store
   function automatic int idx_w(input int nbins);
      return (nbins > 1) ? $clog2(nbins) : 1;
   endfunction

   // block length / position / bin length
   function automatic int len_w(input int block);
      return $clog2(block + 1);
   endfunction

   // bin counter, must hold MAX_BINS + 1
   function automatic int cnt_w(input int nbins);
      return $clog2(nbins + 2);
   endfunction

   // running magnitude sum of one bin
   function automatic int sum_w(input int block);
      return $clog2(longint'(block) * 32768 + 1);
   endfunction

   // bin boundary products (b+1)*T and (p+1)*N
   function automatic int prod_w(input int nbins, input int block);
      return $clog2(longint'(nbins + 1) * longint'(block + 2));
   endfunction

endpackage

// ===== sv/bald_div.sv =====
// Restoring divider, one quotient bit per cycle.
module bald_div import bald_pkg::*; #(
   parameter int NW = 28,
   parameter int DW = 13
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic          busy,
   output logic [NW-1:0] quo
);

   localparam int KW = $clog2(NW + 1);

   logic          busy_ff;
   logic [KW-1:0] cnt_ff;
   logic [DW-1:0] rem_ff;
   logic [DW-1:0] den_ff;
   logic [NW-1:0] quo_ff;

   logic [DW:0]   rem_sh;
   logic          ge;
   logic [DW-1:0] rem_in;

   assign rem_sh = {rem_ff, quo_ff[NW-1]};
   assign ge     = rem_sh >= {1'b0, den_ff};
   assign rem_in = ge ? DW'(rem_sh - {1'b0, den_ff}) : DW'(rem_sh);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= KW'(NW);
      end else if (busy_ff) begin
         busy_ff <= (cnt_ff != KW'(1));
         cnt_ff  <= cnt_ff - KW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         den_ff <= den;
         quo_ff <= num;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[NW-2:0], ge};
      end
   end

   assign busy = busy_ff;
   assign quo  = quo_ff;

endmodule

// ===== sv/bald_queue.sv =====
// Four-entry queue of closed bins between the front and back parts.
module bald_queue import bald_pkg::*; #(
   parameter int W = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] push_data,
   output logic         full,
   input  logic         pop,
   output logic [W-1:0] pop_data,
   output logic         empty
);

   localparam int DEPTH = 4;
   localparam int AW    = $clog2(DEPTH);

   logic [W-1:0]  mem_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff;
   logic [AW-1:0] rd_ptr_ff;
   logic [AW:0]   count_ff;

   assign full     = (count_ff == (AW+1)'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + AW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + AW'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + (AW+1)'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - (AW+1)'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/bald_front.sv =====
// Front part: tracks bin bounds, accumulates magnitudes, queues closed bins.
module bald_front import bald_pkg::*; #(
   parameter  int MAX_BINS  = 64,
   parameter  int MAX_BLOCK = 4096,
   localparam int IW = idx_w(MAX_BINS),
   localparam int TW = len_w(MAX_BLOCK),
   localparam int SW = sum_w(MAX_BLOCK)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [NUM_BINS_W-1:0] num_bins,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  bald_req_type          req_payload,
   output logic                  job_push,
   output logic [IW-1:0]         job_idx,
   output logic [SW-1:0]         job_sum,
   output logic [TW-1:0]         job_len,
   input  logic                  job_full
);

   localparam int BW = cnt_w(MAX_BINS);
   localparam int PW = prod_w(MAX_BINS, MAX_BLOCK);
   localparam int XW = (BLOCK_W > TW) ? BLOCK_W : TW;
   localparam int CW = (NUM_BINS_W > BW) ? NUM_BINS_W : BW;

   typedef enum logic [1:0] {ST_START, ST_OPEN, ST_SCAN, ST_RUN} state_type;

   state_type     state_ff;
   logic [TW-1:0] pos_ff;
   logic [TW-1:0] start_ff;
   logic [TW-1:0] topen_ff;
   logic [TW-1:0] bend_ff;
   logic [BW-1:0] first_ff;
   logic [BW-1:0] b_ff;
   logic [BW-1:0] n_ff;
   logic [PW-1:0] rhs_ff;
   logic [PW-1:0] prod_ff;
   logic [PW-1:0] lim_ff;
   logic [PW-1:0] mark_ff;
   logic          tail_ff;
   logic [IW-1:0] cur_ff;
   logic [SW-1:0] sum_ff;

   logic [XW-1:0] t_ext;
   logic [TW-1:0] t_c;
   logic [CW-1:0] bc_ext;
   logic [BW-1:0] n_eff;
   logic [15:0]   s_u;
   logic [16:0]   mag;
   logic [SW-1:0] sum_nx;
   logic [TW-1:0] pos1;
   logic          acc;
   logic          close_end;
   logic          close_bin;

   assign t_ext = XW'(req_payload.block_samples);
   always_comb begin
      priority if (t_ext == '0) begin
         t_c = TW'(1);
      end else if (t_ext > XW'(MAX_BLOCK)) begin
         t_c = TW'(MAX_BLOCK);
      end else begin
         t_c = TW'(t_ext);
      end
   end

   assign bc_ext = CW'(num_bins);
   always_comb begin
      priority if (bc_ext == '0) begin
         n_eff = BW'(1);
      end else if (bc_ext > CW'(MAX_BINS)) begin
         n_eff = BW'(MAX_BINS);
      end else begin
         n_eff = BW'(bc_ext);
      end
   end

   // most negative sample maps to 32768
   assign s_u    = req_payload.sample;
   assign mag    = s_u[15] ? (17'h10000 - {1'b0, s_u}) : {1'b0, s_u};
   assign sum_nx = sum_ff + SW'(mag);
   assign pos1   = pos_ff + TW'(1);

   // lim holds (b+1)*T; the bin ends at the first position p+1 with (p+2)*N > lim
   assign close_end = (pos1 >= t_c);
   assign close_bin = tail_ff ? (pos1 == bend_ff) : (lim_ff < mark_ff);

   assign req_ready = (state_ff == ST_RUN) && !job_full;
   assign acc       = req_valid && req_ready;
   assign job_push  = acc && (close_end || close_bin);
   assign job_idx   = cur_ff;
   assign job_sum   = sum_nx;
   assign job_len   = pos1 - start_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_START;
         pos_ff   <= '0;
         sum_ff   <= '0;
         tail_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_START: begin
               if (req_valid) begin
                  start_ff <= '0;
                  first_ff <= '0;
                  topen_ff <= t_c;
                  state_ff <= ST_OPEN;
               end
            end
            ST_OPEN: begin
               n_ff     <= n_eff;
               rhs_ff   <= (PW'(start_ff) + PW'(1)) * PW'(n_eff);
               prod_ff  <= (PW'(first_ff) + PW'(1)) * PW'(topen_ff);
               b_ff     <= first_ff;
               state_ff <= ST_SCAN;
            end
            ST_SCAN: begin
               priority if (b_ff >= n_ff) begin
                  // no bin left: tail bin runs to the block end
                  tail_ff  <= 1'b1;
                  cur_ff   <= IW'(n_ff - BW'(1));
                  bend_ff  <= topen_ff;
                  state_ff <= ST_RUN;
               end else if (prod_ff >= rhs_ff) begin
                  tail_ff  <= 1'b0;
                  cur_ff   <= IW'(b_ff);
                  lim_ff   <= prod_ff;
                  mark_ff  <= rhs_ff + PW'(n_ff);
                  state_ff <= ST_RUN;
               end else begin
                  b_ff    <= b_ff + BW'(1);
                  prod_ff <= prod_ff + PW'(topen_ff);
               end
            end
            ST_RUN: begin
               if (acc) begin
                  if (close_end) begin
                     pos_ff   <= '0;
                     sum_ff   <= '0;
                     state_ff <= ST_START;
                  end else if (close_bin) begin
                     pos_ff   <= pos1;
                     sum_ff   <= '0;
                     start_ff <= pos1;
                     first_ff <= BW'(cur_ff) + BW'(1);
                     topen_ff <= t_c;
                     state_ff <= ST_OPEN;
                  end else begin
                     pos_ff  <= pos1;
                     sum_ff  <= sum_nx;
                     mark_ff <= mark_ff + PW'(n_ff);
                  end
               end
            end
            default: state_ff <= ST_START;
         endcase
      end
   end

endmodule

// ===== sv/bald_back.sv =====
// Back part: bin mean by division, clamp, decayed peak update, result register.
module bald_back import bald_pkg::*; #(
   parameter  int MAX_BINS  = 64,
   parameter  int MAX_BLOCK = 4096,
   localparam int IW = idx_w(MAX_BINS),
   localparam int TW = len_w(MAX_BLOCK),
   localparam int SW = sum_w(MAX_BLOCK)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          job_empty,
   input  logic [IW-1:0] job_idx,
   input  logic [SW-1:0] job_sum,
   input  logic [TW-1:0] job_len,
   output logic          job_pop,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output bald_rsp_type  rsp_payload
);

   typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_FIN} state_type;

   state_type          state_ff;
   logic [IW-1:0]      idx_ff;
   logic               rsp_valid_ff;
   bald_rsp_type       rsp_payload_ff;

   logic [LEVEL_W-1:0] store_ff [MAX_BINS];
   logic [MAX_BINS-1:0] vld_ff;
   logic [LEVEL_W-1:0] rd_ff;
   logic               rdv_ff;

   logic               div_busy;
   logic [SW-1:0]      quo;
   logic [LEVEL_W-1:0] lvl;
   logic [LEVEL_W-1:0] old;
   logic [LEVEL_W-1:0] dec;
   logic [LEVEL_W-1:0] nv;
   logic               out_free;
   logic               wr_en;

   bald_div #(
      .NW (SW),
      .DW (TW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (job_pop),
      .num   (job_sum),
      .den   (job_len),
      .busy  (div_busy),
      .quo   (quo)
   );

   assign job_pop  = (state_ff == ST_IDLE) && !job_empty;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign wr_en    = (state_ff == ST_FIN) && out_free;

   assign lvl = (quo > SW'(LEVEL_FULL)) ? LEVEL_FULL : LEVEL_W'(quo);
   assign old = rdv_ff ? rd_ff : '0;
   assign dec = old - (old >> 2);
   assign nv  = (dec > lvl) ? dec : lvl;

   // level store, read when the bin is popped
   always_ff @(posedge clock) begin
      if (job_pop) begin
         rd_ff <= store_ff[job_idx];
      end
      if (wr_en) begin
         store_ff[idx_ff] <= nv;
      end
   end

   // unwritten entries read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[idx_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (job_pop) begin
                  idx_ff   <= job_idx;
                  rdv_ff   <= vld_ff[job_idx];
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (!div_busy) begin
                  state_ff <= ST_FIN;
               end
            end
            ST_FIN: begin
               if (out_free) begin
                  rsp_payload_ff.bin_index <= INDEX_W'(idx_ff);
                  rsp_payload_ff.level     <= nv;
                  state_ff                 <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ===== sv/binned_audio_level_decay.sv =====
// Top level of the binned audio level meter with per-bin peak decay.
// Throughput: one sample per cycle inside a bin while the queue is not full. After a bin closes
// req_ready stays low through ST_OPEN and ST_SCAN, which steps over each empty bin; a block
// start also passes through ST_START. The back part takes one closed bin at a time through
// ST_IDLE, ST_DIV and ST_FIN; a result passes the queue, the divider and the result register.
// Synchronous reset clears the bin count to 16, all levels to zero and the block position.
module binned_audio_level_decay import bald_pkg::*; #(
   parameter int MAX_BINS  = 64,
   parameter int MAX_BLOCK = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  bald_req_type          req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output bald_rsp_type          rsp_payload,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [NUM_BINS_W-1:0] csr_data
);

   localparam int IW = idx_w(MAX_BINS);
   localparam int TW = len_w(MAX_BLOCK);
   localparam int SW = sum_w(MAX_BLOCK);
   localparam int QW = IW + SW + TW;

   logic [NUM_BINS_W-1:0] num_bins_ff;

   logic          job_push;
   logic [IW-1:0] push_idx;
   logic [SW-1:0] push_sum;
   logic [TW-1:0] push_len;
   logic          job_full;
   logic          job_pop;
   logic          job_empty;
   logic [QW-1:0] pop_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_bins_ff <= NUM_BINS_RESET;
      end else if (csr_valid && csr_ready) begin
         num_bins_ff <= csr_data;
      end
   end

   bald_front #(
      .MAX_BINS  (MAX_BINS),
      .MAX_BLOCK (MAX_BLOCK)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .num_bins    (num_bins_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .job_push    (job_push),
      .job_idx     (push_idx),
      .job_sum     (push_sum),
      .job_len     (push_len),
      .job_full    (job_full)
   );

   bald_queue #(
      .W (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data ({push_idx, push_sum, push_len}),
      .full      (job_full),
      .pop       (job_pop),
      .pop_data  (pop_data),
      .empty     (job_empty)
   );

   bald_back #(
      .MAX_BINS  (MAX_BINS),
      .MAX_BLOCK (MAX_BLOCK)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .job_empty   (job_empty),
      .job_idx     (pop_data[QW-1 -: IW]),
      .job_sum     (pop_data[TW +: SW]),
      .job_len     (pop_data[TW-1:0]),
      .job_pop     (job_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== sv/bald_check.sv =====
// Port-level checker for the level meter, bound to the top level.
module bald_check import bald_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input bald_rsp_type rsp_payload
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp beat changed while stalled");

   // a result beat only leaves once taken
   a_rsp_drop: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_valid) && !$past(reset) |-> $past(rsp_ready))
      else $error("rsp beat dropped without ready");

   // level never exceeds full scale
   a_level_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.level <= LEVEL_FULL)
      else $error("level above full scale");

   // nothing taken or offered right after reset
   a_reset_quiet: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid && !req_ready)
      else $error("activity right after reset");

endmodule

bind binned_audio_level_decay bald_check u_bald_check (.*);

// ===== tb/tb.sv =====
// Self-checking testbench for binned_audio_level_decay with a bin-level scoreboard.
`timescale 1ns / 1ps

module tb;
   import bald_pkg::*;

   localparam int CLK_PERIOD   = 8;
   localparam int BIN_LIMIT    = 64;
   localparam int BLOCK_LIMIT  = 4096;
   localparam int FULL_LEVEL   = 32768;
   localparam int RANDOM_ITEMS = 1350;
   localparam int DRAIN_CYCLES = 40;
   localparam int RX_HOLD      = 600;
   localparam int MAX_PRINTS   = 60;
   localparam int TIMEOUT_NS   = 8_000_000;

   // Tracks bin levels and holds the bin updates still owed by the block.
   class level_scoreboard;
      logic [LEVEL_W-1:0] peak [BIN_LIMIT];
      int unsigned bins_reg;
      int unsigned mag_sum;
      int unsigned pos;
      int unsigned cur_bin;
      int unsigned start_pos;
      int unsigned end_pos;
      bald_rsp_type levels_due[$];
      int unsigned mismatches;

      function new();
         foreach (peak[i]) peak[i] = '0;
         bins_reg    = 32'(NUM_BINS_RESET);
         mag_sum     = 0;
         pos         = 0;
         cur_bin     = 0;
         start_pos   = 0;
         end_pos     = 0;
         mismatches  = 0;
      endfunction

      function void set_bins(logic [NUM_BINS_W-1:0] v);
         bins_reg = 32'(v);
      endfunction

      function int unsigned eff_bins();
         if (bins_reg < 1) return 1;
         if (bins_reg > BIN_LIMIT) return BIN_LIMIT;
         return bins_reg;
      endfunction

      function int unsigned upper(int unsigned b, int unsigned t, int unsigned n);
         return ((b + 1) * t) / n;
      endfunction

      // first nonempty bin from 'first' on; past the last bin the tail takes the rest
      function void open_from(int unsigned first, int unsigned t);
         int unsigned n;
         int unsigned b;
         n = eff_bins();
         b = first;
         while (b < n && upper(b, t, n) <= start_pos) b++;
         if (b >= n) begin
            cur_bin = n - 1;
            end_pos = t;
         end else begin
            cur_bin = b;
            end_pos = upper(b, t, n);
         end
      endfunction

      function void note_sample(bald_req_type r);
         int unsigned t;
         int unsigned mag;
         int unsigned nxt;
         int unsigned lvl;
         int unsigned idx;
         int unsigned old;
         int unsigned dec;
         int unsigned nv;
         logic [SAMPLE_W-1:0] u;
         bald_rsp_type e;
         t = 32'(r.block_samples);
         if (t < 1) t = 1;
         if (t > BLOCK_LIMIT) t = BLOCK_LIMIT;
         u = r.sample;
         mag = u[SAMPLE_W-1] ? (32'h10000 - 32'(u)) : 32'(u);
         if (pos == 0) begin
            start_pos = 0;
            open_from(0, t);
         end
         mag_sum += mag;
         nxt = pos + 1;
         if (nxt == end_pos || nxt >= t) begin
            lvl = mag_sum / (nxt - start_pos);
            if (lvl > FULL_LEVEL) lvl = FULL_LEVEL;
            idx = (cur_bin >= BIN_LIMIT) ? BIN_LIMIT - 1 : cur_bin;
            old = 32'(peak[idx]);
            dec = old - (old >> 2);
            nv = (dec > lvl) ? dec : lvl;
            peak[idx] = nv[LEVEL_W-1:0];
            e.bin_index = idx[INDEX_W-1:0];
            e.level = nv[LEVEL_W-1:0];
            levels_due.push_back(e);
            mag_sum = 0;
            if (nxt >= t) begin
               pos = 0;
            end else begin
               pos = nxt;
               start_pos = nxt;
               open_from(cur_bin + 1, t);
            end
         end else begin
            pos = nxt;
         end
      endfunction

      task report(string msg);
         if (mismatches < MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
         mismatches++;
      endtask

      task check_level(bald_rsp_type r);
         bald_rsp_type e;
         if (levels_due.size() == 0) begin
            report($sformatf("unexpected update bin %0d level %0d", r.bin_index, r.level));
            return;
         end
         e = levels_due.pop_front();
         if (r.bin_index !== e.bin_index)
            report($sformatf("bin_index got %0d want %0d", r.bin_index, e.bin_index));
         if (r.level !== e.level)
            report($sformatf("bin %0d level got %0d want %0d", e.bin_index, r.level, e.level));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   bald_req_type req_payload;
   logic rsp_valid;
   logic rsp_ready;
   bald_rsp_type rsp_payload;
   logic csr_valid;
   logic csr_ready;
   logic [NUM_BINS_W-1:0] csr_data;

   level_scoreboard sb;
   bit hold_rx;
   bit tx_steady;
   bit rx_steady;
   int unsigned n_items;

   binned_audio_level_decay u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.set_bins(csr_data);
         if (req_valid && req_ready) sb.note_sample(req_payload);
         if (rsp_valid && rsp_ready) sb.check_level(rsp_payload);
      end
   end

   task automatic push_sample(input logic signed [SAMPLE_W-1:0] s,
                              input logic [BLOCK_W-1:0] t);
      int unsigned gap;
      bald_req_type beat;
      gap = tx_steady ? 0 : $urandom_range(0, 18);
      beat.sample = s;
      beat.block_samples = t;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_payload <= beat;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      n_items++;
   endtask

   // stop offering samples, wait out every owed update plus the back-end latency
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.levels_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_bins(input logic [NUM_BINS_W-1:0] v);
      csr_data <= v;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [NUM_BINS_W-1:0] pick_bins();
      case ($urandom_range(0, 9))
         0: return 7'd0;
         1: return 7'd1;
         2: return 7'd64;
         3: return 7'($urandom_range(65, 127));
         4, 5: return 7'($urandom_range(1, 8));
         default: return 7'($urandom_range(1, 64));
      endcase
   endfunction

   function automatic logic [BLOCK_W-1:0] pick_length();
      case ($urandom_range(0, 19))
         0: return 13'd0;
         1, 2, 3: return 13'($urandom_range(41, 300));
         4: return 13'($urandom_range(3000, 8191));
         default: return 13'($urandom_range(1, 40));
      endcase
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] pick_sample(input int unsigned style,
                                                              input logic [SAMPLE_W-1:0] loud);
      logic [31:0] r;
      r = $urandom;
      case (style)
         0: return r[SAMPLE_W-1:0];
         1: begin
            case (r[2:0])
               3'd0, 3'd5: return 16'h8000;
               3'd1, 3'd6: return 16'h7FFF;
               3'd2: return 16'h0000;
               3'd3: return 16'hFFFF;
               default: return 16'h0001;
            endcase
         end
         2: return loud ^ {10'd0, r[5:0]};
         3: begin
            r = $urandom_range(0, 511) - 256;
            return r[SAMPLE_W-1:0];
         end
         default: return (r[4:2] == 3'd0) ? r[31:16] : 16'h0000;
      endcase
   endfunction

   // one block, possibly shortened or re-binned partway through
   task automatic run_block();
      logic [BLOCK_W-1:0] t_cur;
      logic [SAMPLE_W-1:0] loud;
      int unsigned done;
      int unsigned lim;
      int unsigned style;
      int unsigned cut_at;
      int unsigned retune_at;
      t_cur = pick_length();
      style = $urandom_range(0, 4);
      loud = 16'($urandom);
      if (t_cur > 300) cut_at = $urandom_range(1, 40);
      else cut_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 30) : 0;
      retune_at = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 30) : 0;
      done = 0;
      forever begin
         if (done != 0 && done == retune_at) begin
            settle();
            write_bins(7'($urandom_range(0, 8)));
         end
         if (done != 0 && done == cut_at) t_cur = 13'($urandom_range(0, done + 20));
         push_sample(pick_sample(style, loud), t_cur);
         done++;
         lim = (t_cur == 0) ? 1 : ((t_cur > BLOCK_LIMIT) ? BLOCK_LIMIT : 32'(t_cur));
         if (done >= lim) break;
      end
   endtask

   task automatic run_directed();
      // reset bin count: one-sample blocks land in the last bin
      push_sample(16'sh8000, 13'd1);
      push_sample(16'sh7FFF, 13'd0);
      settle();
      write_bins(7'd0);
      push_sample(16'sh7FFF, 13'd3);
      push_sample(16'sh8000, 13'd3);
      push_sample(16'sh0000, 13'd3);
      settle();
      write_bins(7'd127);
      push_sample(16'sh0001, 13'd2);
      push_sample(16'shFFFF, 13'd2);
      // oversize length, then the block is cut short by later beats
      push_sample(16'sd100, 13'h1FFF);
      push_sample(-16'sd100, 13'd4096);
      push_sample(16'sd5, 13'd2);
      settle();
      write_bins(7'd4);
      repeat (5) push_sample(-16'sd20000, 13'd16);
      // shrink mid-block so no bin remains: the rest goes to a tail bin
      settle();
      write_bins(7'd1);
      repeat (11) push_sample(16'sd12345, 13'd16);
   endtask

   task automatic run_random();
      int unsigned phase;
      int unsigned start;
      int unsigned blocks;
      phase = 0;
      start = n_items;
      while (n_items - start < RANDOM_ITEMS) begin
         settle();
         write_bins(pick_bins());
         tx_steady = ($urandom_range(0, 3) == 0);
         rx_steady = ($urandom_range(0, 3) == 0);
         if (phase % 15 == 3) begin
            // results pile up behind a stalled receiver until the input backs up
            hold_rx = 1'b1;
            tx_steady = 1'b1;
            repeat (48) push_sample(pick_sample(0, 16'h0), 13'd1);
         end else begin
            blocks = $urandom_range(1, 6);
            repeat (blocks) run_block();
         end
         phase++;
      end
   endtask

   initial begin : rx_side
      int unsigned pause;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_rx) begin
            rsp_ready <= 1'b0;
            repeat (RX_HOLD) @(posedge clock);
            hold_rx = 1'b0;
         end
         pause = rx_steady ? 0 : $urandom_range(0, 18);
         if (pause != 0) begin
            rsp_ready <= 1'b0;
            repeat (pause) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_valid || hold_rx)) @(posedge clock);
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_data = '0;
      hold_rx = 1'b0;
      tx_steady = 1'b0;
      rx_steady = 1'b0;
      n_items = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      run_random();
      settle();
      if (sb.levels_due.size() != 0)
         sb.report($sformatf("%0d bin updates never arrived", sb.levels_due.size()));
      if (sb.mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== binned_audio_level_decay.f =====
sv/bald_pkg.sv
sv/bald_div.sv
sv/bald_queue.sv
sv/bald_front.sv
sv/bald_back.sv
sv/binned_audio_level_decay.sv
sv/bald_check.sv
tb/tb.sv
